FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define UPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition at one edge implies a property at the next edge.
`define UPD_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

FILE: hdl/upd_pkg.sv
// Shared types and constants of the URL percent decoder.
// No dependencies; the front end, queue, back end, top level and bench refer to it by scoped names.
`timescale 1ns / 1ps

package upd_pkg;

  localparam int COUNT_BITS  = 12;
  localparam int LIMIT_BITS  = 13;
  localparam int BOUND_BITS  = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS   = 3;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 13'd2048;
  localparam logic [0:0]            REG_OUT_LIMIT = 1'b0;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  // Decoded bytes released by one item, plus an optional terminator.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] data;
    logic            term;
  } bundle_t;

endpackage

FILE: hdl/url_percent_decoder_core.sv
// Top level of the URL percent decoder: APB register, front end, queue, back end.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
// Usage: at most one encoded character per input item (in_byte_i, carries_byte_i,
// string_end_i) on a valid/stall channel; decoded bytes and a closing
// terminator (is_terminator_o, was_truncated_o) leave on a second
// valid/stall channel. An item is taken at an edge with valid high and
// stall low on its channel.
// The first result of an item passes through the bundle queue and then the
// output register. Throughput: one item per cycle while the queue has room;
// the back end handles each result and each byte dropped by the limit in turn,
// so items that release several bytes fill the four-entry bundle queue and
// in_stall_o rises when it is full.
// A stalled result holds in the output register; the back end then pauses
// and the queue absorbs further items.
// Reset clears the escape state, counters, queue and output register and
// loads out_limit with 2048. Write out_limit (byte address 0) only between
// strings while the block is idle.
`timescale 1ns / 1ps

module url_percent_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          carries_byte_i,
  input  logic                          string_end_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          is_terminator_o,
  output logic                          was_truncated_o
);

  logic [upd_pkg::LIMIT_BITS-1:0] out_limit_q;
  logic             reg_sel;
  logic             push, pop, q_empty, q_full;
  upd_pkg::bundle_t push_bundle, head_bundle;

  // Register index lives in paddr[2]; only index 0 exists.
  assign reg_sel = (paddr[2] == upd_pkg::REG_OUT_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32 - upd_pkg::LIMIT_BITS){1'b0}}, out_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= upd_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      out_limit_q <= pwdata[upd_pkg::LIMIT_BITS-1:0];
    end
  end

  // Front end: decode characters, hand bundles to the queue.
  upd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_i      (in_byte_i),
    .carries_byte_i (carries_byte_i),
    .string_end_i   (string_end_i),
    .q_full_i       (q_full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .bundle_o       (push_bundle)
  );

  // Decouple the two ends so each can stall on its own.
  upd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Back end: limit bytes, emit results through the output register.
  upd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .out_limit_i     (out_limit_q),
    .head_i          (head_bundle),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .is_terminator_o (is_terminator_o),
    .was_truncated_o (was_truncated_o)
  );

endmodule

FILE: hdl/upd_front.sv
// Front end: accepts input items, tracks escape state, builds result bundles.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              carries_byte_i,
  input  logic              string_end_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output upd_pkg::bundle_t  bundle_o
);

  logic [1:0] held_q, held_d;
  logic [7:0] digit_q, digit_d;
  logic       closed_q, closed_d;
  logic       accept;
  logic [4:0] hx_c, hx_d;
  logic       plain_pct;
  logic [7:0] plain_byte;
  upd_pkg::bundle_t bd;

  // {valid, value} of a hex digit character
  function automatic logic [4:0] hex_fn(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= upd_pkg::CH_LO_A && c <= upd_pkg::CH_LO_F) ||
                 (c >= upd_pkg::CH_UP_A && c <= upd_pkg::CH_UP_F)) begin
      r = {1'b1, c[3:0] + (upd_pkg::HEX_TEN - 4'd1)};
    end
    return r;
  endfunction

  function automatic upd_pkg::bundle_t add_byte(upd_pkg::bundle_t b, logic [7:0] v);
    upd_pkg::bundle_t r;
    r = b;
    r.data[b.n] = v;
    r.n = b.n + 2'd1;
    return r;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hx_c       = hex_fn(in_byte_i);
  assign hx_d       = hex_fn(digit_q);
  assign plain_pct  = (in_byte_i == upd_pkg::CH_PCT);
  assign plain_byte = (in_byte_i == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte_i;

  always_comb begin
    held_d   = held_q;
    digit_d  = digit_q;
    closed_d = closed_q;
    bd       = '0;
    if (carries_byte_i && !closed_q) begin
      if (in_byte_i == 8'd0) begin
        if (held_q != 2'd0) bd = add_byte(bd, upd_pkg::CH_PCT);
        if (held_q == 2'd2) bd = add_byte(bd, digit_q);
        held_d   = 2'd0;
        closed_d = 1'b1;
      end else if (held_q == 2'd1) begin
        if (plain_pct) begin
          bd = add_byte(bd, upd_pkg::CH_PCT);
        end else if (hx_c[4]) begin
          held_d  = 2'd2;
          digit_d = in_byte_i;
        end else begin
          bd     = add_byte(bd, upd_pkg::CH_PCT);
          held_d = 2'd0;
          bd     = add_byte(bd, plain_byte);
        end
      end else if (held_q == 2'd2) begin
        held_d = 2'd0;
        if (hx_c[4]) begin
          bd = add_byte(bd, {hx_d[3:0], hx_c[3:0]});
        end else begin
          bd = add_byte(bd, upd_pkg::CH_PCT);
          bd = add_byte(bd, digit_q);
          if (plain_pct) held_d = 2'd1;
          else bd = add_byte(bd, plain_byte);
        end
      end else begin
        if (plain_pct) held_d = 2'd1;
        else bd = add_byte(bd, plain_byte);
      end
    end
    if (string_end_i) begin
      // flush whatever is still held, then close the string
      if (!closed_d) begin
        if (held_d != 2'd0) bd = add_byte(bd, upd_pkg::CH_PCT);
        if (held_d == 2'd2) bd = add_byte(bd, digit_d);
      end
      bd.term  = 1'b1;
      held_d   = 2'd0;
      digit_d  = 8'd0;
      closed_d = 1'b0;
    end
  end

  assign push_o   = accept && (bd.term || (bd.n != 2'd0));
  assign bundle_o = bd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 2'd0;
      digit_q  <= 8'd0;
      closed_q <= 1'b0;
    end else if (accept) begin
      held_q   <= held_d;
      digit_q  <= digit_d;
      closed_q <= closed_d;
    end
  end

endmodule

FILE: hdl/upd_queue.sv
// Short bundle queue between front and back end.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  upd_pkg::bundle_t  push_data_i,
  input  logic              pop_i,
  output upd_pkg::bundle_t  head_o,
  output logic              empty_o,
  output logic              full_o
);

  upd_pkg::bundle_t mem_q [upd_pkg::QUEUE_DEPTH];
  logic [upd_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [upd_pkg::QCNT_BITS-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == upd_pkg::QCNT_BITS'(upd_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/upd_back.sv
// Back end: walks each bundle one result a cycle unless the output stalls, applies the output limit.
// Depends on upd_pkg.
`timescale 1ns / 1ps

module upd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [upd_pkg::LIMIT_BITS-1:0] out_limit_i,
  input  upd_pkg::bundle_t               head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           is_terminator_o,
  output logic                           was_truncated_o
);

  localparam int CB = upd_pkg::COUNT_BITS;
  localparam int BW = upd_pkg::BOUND_BITS;

  logic [CB-1:0] bound_q, bound_d;
  logic [CB-1:0] count_q;
  logic          hit_q;
  logic [1:0]    idx_q;
  logic          valid_q;
  logic [7:0]    byte_q;
  logic          term_q, trunc_q;

  logic [BW-1:0] lim_m1, top;
  logic          step, is_data, last, room;
  logic [2:0]    nxt, total;

  // data byte bound: max(limit,1)-1, saturated at the counter range
  assign top     = BW'({CB{1'b1}});
  assign lim_m1  = (out_limit_i == '0) ? '0 : (BW'(out_limit_i) - 1'b1);
  assign bound_d = (lim_m1 > top) ? top[CB-1:0] : lim_m1[CB-1:0];

  assign step    = !empty_i && (!valid_q || !out_stall_i);
  assign is_data = ({1'b0, idx_q} < {1'b0, head_i.n});
  assign nxt     = {1'b0, idx_q} + 3'd1;
  assign total   = {1'b0, head_i.n} + {2'b00, head_i.term};
  assign last    = (nxt == total);
  assign room    = (count_q < bound_q);
  assign pop_o   = step && last;

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hit_q   <= 1'b0;
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (step) begin
        idx_q <= last ? 2'd0 : nxt[1:0];
        if (is_data) begin
          // a dropped byte leaves the output register empty
          valid_q <= room;
          if (room) begin
            count_q <= count_q + 1'b1;
          end else begin
            hit_q <= 1'b1;
          end
        end else begin
          valid_q <= 1'b1;
          count_q <= '0;
          hit_q   <= 1'b0;
        end
      end else if (valid_q && !out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q  <= is_data ? head_i.data[idx_q] : 8'd0;
      term_q  <= !is_data;
      trunc_q <= !is_data && hit_q;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign is_terminator_o = term_q;
  assign was_truncated_o = trunc_q;

endmodule

FILE: hdl/upd_checker.sv
// Port-level checker for url_percent_decoder_core, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       is_terminator_o,
  input logic       was_truncated_o
);

  logic [9:0] out_word;

  assign out_word = {out_byte_o, is_terminator_o, was_truncated_o};

  `UPD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `UPD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))
  `UPD_ASSERT(a_term_zero, !(out_valid_o && is_terminator_o) || (out_byte_o == 8'd0))
  `UPD_ASSERT(a_trunc_term, !(out_valid_o && was_truncated_o) || is_terminator_o)

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .is_terminator_o (is_terminator_o),
  .was_truncated_o (was_truncated_o)
);

FILE: bench/tb.sv
// Self-checking bench for url_percent_decoder_core: random and directed strings with an
// in-bench decoding predictor. Depends on upd_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb;

  // APB byte addresses: the limit register, and an unused slot that must ignore writes.
  localparam logic [upd_pkg::ADDR_BITS-1:0] LIMIT_ADDR = {upd_pkg::REG_OUT_LIMIT, 2'b00};
  localparam logic [upd_pkg::ADDR_BITS-1:0] SPARE_ADDR = 3'd4;
  localparam logic [7:0]                    CH_NUL     = 8'h00;
  localparam int                            BYTE_TOP   = (1 << upd_pkg::COUNT_BITS) - 1;
  localparam int                            SETTLE     = 32;

  // Idle styles for either side of the block.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_FULL = 1;
  localparam int IDLE_RARE = 2;

  // Escape progress: nothing held, a '%' held, a '%' and one hex digit held.
  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       trunc;
  } dec_res_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [upd_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    in_byte_i = '0;
  logic                          carries_byte_i = 1'b0;
  logic                          string_end_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    out_byte_o;
  logic                          is_terminator_o;
  logic                          was_truncated_o;

  // Encoded characters waiting to be sent, and decoded bytes waiting to come out.
  enc_item_t pending_chars[$];
  dec_res_t  decoded_fifo[$];

  // Predictor copy of the decoder state and its limit register.
  logic [upd_pkg::LIMIT_BITS-1:0] cfg_limit = upd_pkg::LIMIT_RESET;
  esc_e                           esc_held = ESC_NONE;
  logic [7:0]                     esc_digit = '0;
  logic [upd_pkg::COUNT_BITS-1:0] bytes_out = '0;
  logic                           str_closed = 1'b0;
  logic                           limit_hit = 1'b0;

  int send_mode = IDLE_NONE;
  int recv_mode = IDLE_NONE;
  int gap_left = 0;
  int stall_left = 0;
  int stall_draw;
  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int strings_done = 0;
  int trunc_strings = 0;
  int cfg_writes = 0;
  int fail_cnt = 0;

  enc_item_t nxt_char;
  dec_res_t  mon_want;

  url_percent_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .carries_byte_i  (carries_byte_i),
    .string_end_i    (string_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .is_terminator_o (is_terminator_o),
    .was_truncated_o (was_truncated_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_fail(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", what);
  endtask

  function automatic int draw_wait(input int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(15, 0);
      default:   return ($urandom_range(7, 0) == 0) ? $urandom_range(15, 0) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Value of a hex digit, or -1 for anything outside 0-9, a-f, A-F.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE)
      return int'(c - upd_pkg::CH_ZERO);
    if (c >= upd_pkg::CH_LO_A && c <= upd_pkg::CH_LO_F)
      return int'(c - upd_pkg::CH_LO_A) + int'(upd_pkg::HEX_TEN);
    if (c >= upd_pkg::CH_UP_A && c <= upd_pkg::CH_UP_F)
      return int'(c - upd_pkg::CH_UP_A) + int'(upd_pkg::HEX_TEN);
    return -1;
  endfunction

  // Data bytes allowed per string: limit minus one, a zero limit acting as one,
  // capped by what the byte counter can hold.
  function automatic int byte_bound();
    int lim;
    lim = (cfg_limit == '0) ? 1 : int'(cfg_limit);
    lim = lim - 1;
    return (lim < BYTE_TOP) ? lim : BYTE_TOP;
  endfunction

  // Pass one data byte, or drop it and remember the drop once the limit is reached.
  task automatic emit_byte(input logic [7:0] b);
    if (int'(bytes_out) < byte_bound()) begin
      decoded_fifo.push_back(dec_res_t'{b, 1'b0, 1'b0});
      bytes_out = bytes_out + 1'b1;
    end else begin
      limit_hit = 1'b1;
    end
  endtask

  task automatic lit_char(input logic [7:0] c);
    if (c == upd_pkg::CH_PLUS) emit_byte(upd_pkg::CH_SPACE);
    else if (c == upd_pkg::CH_PCT) esc_held = ESC_PCT;
    else emit_byte(c);
  endtask

  // Release a half-finished escape as literal characters.
  task automatic spill_escape();
    if (esc_held == ESC_PCT || esc_held == ESC_DIGIT) emit_byte(upd_pkg::CH_PCT);
    if (esc_held == ESC_DIGIT) emit_byte(esc_digit);
    esc_held = ESC_NONE;
  endtask

  task automatic feed_char(input logic [7:0] c);
    int v;
    int hi;
    v = hex_nibble(c);
    if (str_closed) return;
    if (c == CH_NUL) begin
      spill_escape();
      str_closed = 1'b1;
      return;
    end
    case (esc_held)
      ESC_PCT: begin
        if (c == upd_pkg::CH_PCT) begin
          emit_byte(upd_pkg::CH_PCT);
        end else if (v >= 0) begin
          esc_held = ESC_DIGIT;
          esc_digit = c;
        end else begin
          emit_byte(upd_pkg::CH_PCT);
          esc_held = ESC_NONE;
          lit_char(c);
        end
      end
      ESC_DIGIT: begin
        if (v >= 0) begin
          hi = hex_nibble(esc_digit);
          emit_byte({hi[3:0], v[3:0]});
          esc_held = ESC_NONE;
        end else begin
          emit_byte(upd_pkg::CH_PCT);
          emit_byte(esc_digit);
          esc_held = ESC_NONE;
          lit_char(c);
        end
      end
      default: begin
        esc_held = ESC_NONE;
        lit_char(c);
      end
    endcase
  endtask

  // Expected results of one accepted item, in order.
  task automatic decode_item(input logic [7:0] c, input logic has, input logic fin);
    if (has) feed_char(c);
    if (fin) begin
      if (!str_closed) spill_escape();
      decoded_fifo.push_back(dec_res_t'{8'h00, 1'b1, limit_hit});
      strings_done++;
      if (limit_hit) trunc_strings++;
      esc_held = ESC_NONE;
      esc_digit = '0;
      bytes_out = '0;
      str_closed = 1'b0;
      limit_hit = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take items from pending_chars, hold each until accepted, then idle
  // for the drawn number of cycles before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_item(in_byte_i, carries_byte_i, string_end_i);
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_chars.size() != 0) begin
          nxt_char = pending_chars.pop_front();
          in_byte_i <= nxt_char.data;
          carries_byte_i <= nxt_char.has;
          string_end_i <= nxt_char.fin;
          in_valid_i <= 1'b1;
          gap_left <= draw_wait(send_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest expectation, then
  // stall for the drawn number of cycles before taking the next.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (decoded_fifo.size() == 0) begin
        report_fail($sformatf("unexpected result byte=%02h term=%b trunc=%b",
                              out_byte_o, is_terminator_o, was_truncated_o));
      end else begin
        mon_want = decoded_fifo.pop_front();
        if (out_byte_o !== mon_want.data || is_terminator_o !== mon_want.term ||
            was_truncated_o !== mon_want.trunc)
          report_fail($sformatf(
            "result %0d: expected byte=%02h term=%b trunc=%b, got byte=%02h term=%b trunc=%b",
            results_seen, mon_want.data, mon_want.term, mon_want.trunc,
            out_byte_o, is_terminator_o, was_truncated_o));
      end
      results_seen++;
      stall_draw = draw_wait(recv_mode);
      stall_left <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [upd_pkg::ADDR_BITS-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == LIMIT_ADDR) cfg_limit = data[upd_pkg::LIMIT_BITS-1:0];
    cfg_writes++;
  endtask

  // Read the limit back and compare it with the predictor's copy.
  task automatic check_limit();
    logic [31:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {{(32 - upd_pkg::LIMIT_BITS){1'b0}}, cfg_limit})
      report_fail($sformatf("out_limit read: expected %0d, got %0d", cfg_limit, rd));
  endtask

  // Random junk above the register's width must be dropped by the write.
  task automatic set_limit(input int lim);
    logic [31:0] word;
    word = $urandom();
    word[upd_pkg::LIMIT_BITS-1:0] = lim[upd_pkg::LIMIT_BITS-1:0];
    apb_write(LIMIT_ADDR, word);
    check_limit();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, input logic has, input logic fin);
    pending_chars.push_back(enc_item_t'{c, has, fin});
    items_queued++;
  endtask

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(21, 0);
    if (r < 10) return upd_pkg::CH_ZERO + 8'(r);
    if (r < 16) return upd_pkg::CH_LO_A + 8'(r - 10);
    return upd_pkg::CH_UP_A + 8'(r - 16);
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == upd_pkg::CH_PCT);
    return c;
  endfunction

  // One string: mostly valid escapes and plain text, with broken escapes,
  // zero characters, empty items and raw bytes mixed in.
  task automatic push_string(input int max_len);
    int n;
    int kind;
    n = $urandom_range(max_len, 0);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99, 0);
      if (kind < 35) begin
        push_char(rand_plain(), 1'b1, 1'b0);
      end else if (kind < 45) begin
        push_char(upd_pkg::CH_PLUS, 1'b1, 1'b0);
      end else if (kind < 70) begin
        push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
        push_char(rand_hex(), 1'b1, 1'b0);
        push_char(rand_hex(), 1'b1, 1'b0);
      end else if (kind < 80) begin
        push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
        if ($urandom_range(1, 0)) push_char(rand_hex(), 1'b1, 1'b0);
        if ($urandom_range(3, 0) != 0) push_char(rand_nonhex(), 1'b1, 1'b0);
      end else if (kind < 86) begin
        push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
        push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
      end else if (kind < 90) begin
        push_char(CH_NUL, 1'b1, 1'b0);
      end else if (kind < 95) begin
        push_char(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      end else begin
        push_char(8'($urandom_range(255, 0)), 1'b1, 1'b0);
      end
    end
    // Close either with a last character or with an end-only item.
    push_char(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1);
  endtask

  task automatic push_strings(input int count, input int max_len);
    int start;
    start = items_queued;
    while (items_queued - start < count) push_string(max_len);
  endtask

  // Hold off until every queued item is accepted and every expected result
  // is out, then let any dropped-byte work inside the block finish.
  task automatic drain();
    while (items_sent != items_queued || decoded_fifo.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic pick_idle(input int k);
    send_mode = k % 3;
    recv_mode = (k + 1) % 3;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limit();

    // Hand-picked string: plain, '+', both hex cases, '%%' starting a new
    // escape into a zero data byte, a non-hex digit, escape broken by '+',
    // top-bit bytes and a lone '%' flushed by an end-only item.
    pick_idle(1);
    @(negedge clk_i);
    push_char("a", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PLUS, 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("4", 1'b1, 1'b0);
    push_char("1", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("f", 1'b1, 1'b0);
    push_char("F", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("0", 1'b1, 1'b0);
    push_char("0", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("g", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("A", 1'b1, 1'b0);
    push_char(upd_pkg::CH_PLUS, 1'b1, 1'b0);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(8'h80, 1'b1, 1'b0);
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char(8'h5A, 1'b0, 1'b1);
    // Empty item between strings: nothing should come out.
    push_char(8'hA5, 1'b0, 1'b0);
    // Zero character flushes '%9' and closes; the rest is ignored until the end.
    push_char(upd_pkg::CH_PCT, 1'b1, 1'b0);
    push_char("9", 1'b1, 1'b0);
    push_char(CH_NUL, 1'b1, 1'b0);
    push_char("y", 1'b1, 1'b1);
    drain();

    pick_idle(2);
    @(negedge clk_i);
    push_strings(40, 12);
    drain();

    // Limit of one: no data bytes at all, every non-empty string truncated.
    set_limit(1);
    pick_idle(0);
    @(negedge clk_i);
    push_strings(25, 6);
    drain();

    // Zero limit behaves like one.
    set_limit(0);
    pick_idle(1);
    @(negedge clk_i);
    push_strings(15, 6);
    drain();

    // Small limit: truncation inside escapes and flushes.
    set_limit(4);
    pick_idle(2);
    @(negedge clk_i);
    push_strings(30, 10);
    drain();

    // Write to the unused address must leave the limit alone.
    apb_write(SPARE_ADDR, $urandom());
    check_limit();

    // Largest limit: the byte bound is capped by the counter range.
    set_limit((1 << upd_pkg::LIMIT_BITS) - 1);
    pick_idle(0);
    @(negedge clk_i);
    push_strings(20, 12);
    drain();

    set_limit(4096);
    pick_idle(1);
    @(negedge clk_i);
    push_strings(30, 12);
    drain();

    set_limit(7);
    pick_idle(2);
    @(negedge clk_i);
    push_strings(30, 12);
    drain();

    if (decoded_fifo.size() != 0)
      report_fail($sformatf("%0d results never arrived", decoded_fifo.size()));

    $display("covered %0d items in %0d strings, %0d results checked, %0d strings truncated",
             items_sent, strings_done, results_seen, trunc_strings);
    $display("%0d register writes, %0d mismatches", cfg_writes, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_core.sv
hdl/upd_checker.sv
bench/tb.sv
